// File: rtl/core/uct_pkg.sv
`timescale 1ns / 1ps
// Package for the Unicode character class tagger: class, merge and tag codes,
// code point range bounds and the small set-membership and lookup functions.
// No dependencies.
package uct_pkg;

	typedef logic [20:0] code_point_t;

	typedef enum logic [3:0] {
		CLS_SPACE,
		CLS_HANGUL,
		CLS_LATIN,
		CLS_NUMBER,
		CLS_CJK,
		CLS_ELLIPSIS,
		CLS_PERIOD,
		CLS_OMARK,
		CLS_COMMA,
		CLS_QUOTE,
		CLS_SYMBOL,
		CLS_FOREIGN
	} char_class_t;

	localparam int NUM_CLASSES = 12;
	typedef logic [NUM_CLASSES-1:0] class_hits_t;

	typedef enum logic [1:0] {
		MERGE_SEPARATE,
		MERGE_BY_CHAR,
		MERGE_BY_TYPE
	} merge_mode_t;

	typedef enum logic [3:0] {
		TAG_NNG,
		TAG_SL,
		TAG_SN,
		TAG_SH,
		TAG_SE,
		TAG_SF,
		TAG_SO,
		TAG_SP,
		TAG_SS,
		TAG_SW
	} pos_tag_t;

	localparam code_point_t HANGUL_SYL_LO  = 21'h00AC00;
	localparam code_point_t HANGUL_SYL_HI  = 21'h00D7AF;
	localparam code_point_t HANGUL_JAMO_LO = 21'h001100;
	localparam code_point_t HANGUL_JAMO_HI = 21'h0011FF;
	localparam code_point_t CJK_UNI_LO     = 21'h004E00;
	localparam code_point_t CJK_UNI_HI     = 21'h009FD5;
	localparam code_point_t CJK_COMPAT_LO  = 21'h00F900;
	localparam code_point_t CJK_COMPAT_HI  = 21'h00FAD9;
	localparam code_point_t CJK_RADICAL_LO = 21'h002F00;
	localparam code_point_t CJK_RADICAL_HI = 21'h002FDF;
	localparam code_point_t LATIN1_LO      = 21'h0000C0;
	localparam code_point_t LATIN1_HI      = 21'h0000FF;
	localparam code_point_t LATIN1_MUL     = 21'h0000D7;
	localparam code_point_t LATIN1_DIV     = 21'h0000F7;
	localparam code_point_t ELLIPSIS_CP    = 21'h002026;

	function automatic logic space_char(input code_point_t c);
		case (c)
			21'h000020, 21'h000009, 21'h00000B, 21'h00000D, 21'h00000A,
			21'h003000: space_char = 1'b1;
			default: space_char = 1'b0;
		endcase
	endfunction

	function automatic logic period_char(input code_point_t c);
		case (c)
			21'h00002E, 21'h00FF0E, 21'h00FF61, 21'h00003F, 21'h00FF1F,
			21'h000021, 21'h00FF01: period_char = 1'b1;
			default: period_char = 1'b0;
		endcase
	endfunction

	function automatic logic omark_char(input code_point_t c);
		case (c)
			21'h00007E, 21'h00FF5E, 21'h0025CB, 21'h0025EF,
			21'h0025A1: omark_char = 1'b1;
			default: omark_char = 1'b0;
		endcase
	endfunction

	function automatic logic comma_char(input code_point_t c);
		case (c)
			21'h00002C, 21'h00FF0C, 21'h00FF64, 21'h00FF65, 21'h00003A,
			21'h00FF1A, 21'h00003B, 21'h00FF1B, 21'h00002F,
			21'h00FF0F: comma_char = 1'b1;
			default: comma_char = 1'b0;
		endcase
	endfunction

	function automatic logic quote_char(input code_point_t c);
		case (c)
			21'h000027, 21'h00FF07, 21'h002018, 21'h002019, 21'h000022,
			21'h00FF02, 21'h00201C, 21'h00201D, 21'h00002D, 21'h00FF0D,
			21'h000028, 21'h000029, 21'h00FF08, 21'h00FF09, 21'h00005B,
			21'h00005D, 21'h00FF3B, 21'h00FF3D, 21'h00007B, 21'h00007D,
			21'h00FF5B, 21'h00FF5D, 21'h00003C, 21'h00003E, 21'h00FF1C,
			21'h00FF1E: quote_char = 1'b1;
			default: quote_char = 1'b0;
		endcase
	endfunction

	function automatic logic symbol_char(input code_point_t c);
		case (c)
			21'h000060, 21'h000040, 21'h000023, 21'h000024, 21'h000025,
			21'h00005E, 21'h000026, 21'h00002A, 21'h00005F, 21'h00003D,
			21'h00002B, 21'h00007C, 21'h00005C,
			21'h00FF03, 21'h00FF04, 21'h00FF05, 21'h00FF06, 21'h00FF0A,
			21'h00FF0B, 21'h00FF1D, 21'h00FF20, 21'h00FF3C, 21'h00FF3E,
			21'h00FF3F, 21'h00FF40, 21'h00FF5C: symbol_char = 1'b1;
			default: symbol_char = 1'b0;
		endcase
	endfunction

	function automatic merge_mode_t merge_of(input char_class_t cls);
		case (cls)
			CLS_ELLIPSIS, CLS_PERIOD, CLS_OMARK: merge_of = MERGE_BY_CHAR;
			CLS_COMMA, CLS_QUOTE, CLS_SYMBOL:    merge_of = MERGE_SEPARATE;
			default:                             merge_of = MERGE_BY_TYPE;
		endcase
	endfunction

	// space has no tag; it reads as NNG and the error flag is raised instead
	function automatic pos_tag_t tag_of(input char_class_t cls);
		case (cls)
			CLS_LATIN:    tag_of = TAG_SL;
			CLS_FOREIGN:  tag_of = TAG_SL;
			CLS_NUMBER:   tag_of = TAG_SN;
			CLS_CJK:      tag_of = TAG_SH;
			CLS_ELLIPSIS: tag_of = TAG_SE;
			CLS_PERIOD:   tag_of = TAG_SF;
			CLS_OMARK:    tag_of = TAG_SO;
			CLS_COMMA:    tag_of = TAG_SP;
			CLS_QUOTE:    tag_of = TAG_SS;
			CLS_SYMBOL:   tag_of = TAG_SW;
			default:      tag_of = TAG_NNG;
		endcase
	endfunction

endpackage

// File: rtl/core/unicode_char_class_tagger_core.sv
`timescale 1ns / 1ps
// Unicode character class tagger: three-stage pipeline from code point to
// class, merge mode and part-of-speech tag. Depends on uct_pkg.
// Pipeline: 3 register stages lie between an input transaction and its output.
// Throughput: one transaction per cycle; each stage holds while the next is full and stalled.
// Stage 1 registers the per-class match vector, stage 2 the priority-encoded
// class, stage 3 the output fields. Reset clears all stage valid bits.
module unicode_char_class_tagger_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [20:0] code_point, zero padded
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [3:0] char_class, [5:4] merge_mode, [9:6] pos_tag
	output logic        m_tuser    // [0] tag_error
);
	import uct_pkg::*;

	code_point_t c;
	class_hits_t hits_d;
	class_hits_t hits_s1;
	logic        v_s1, v_s2, v_s3;
	char_class_t cls_d, cls_s2, cls_s3;
	merge_mode_t merge_s3;
	pos_tag_t    tag_s3;
	logic        err_s3;
	logic        adv_s1, adv_s2, adv_s3;

	assign c = s_tdata[20:0];

	// a stage loads when it is empty or its content moves on this cycle
	assign adv_s3   = !v_s3 || m_tready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_comb begin
		hits_d               = '0;
		hits_d[CLS_SPACE]    = space_char(c);
		hits_d[CLS_HANGUL]   = (c >= HANGUL_SYL_LO && c <= HANGUL_SYL_HI) ||
		                       (c >= HANGUL_JAMO_LO && c <= HANGUL_JAMO_HI);
		hits_d[CLS_LATIN]    = (c >= 21'h000041 && c <= 21'h00005A) ||
		                       (c >= 21'h00FF21 && c <= 21'h00FF3A) ||
		                       (c >= 21'h000061 && c <= 21'h00007A) ||
		                       (c >= 21'h00FF41 && c <= 21'h00FF5A) ||
		                       (c >= LATIN1_LO && c <= LATIN1_HI &&
		                        c != LATIN1_MUL && c != LATIN1_DIV);
		hits_d[CLS_NUMBER]   = (c >= 21'h000030 && c <= 21'h000039) ||
		                       (c >= 21'h00FF10 && c <= 21'h00FF19);
		hits_d[CLS_CJK]      = (c >= CJK_UNI_LO && c <= CJK_UNI_HI) ||
		                       (c >= CJK_COMPAT_LO && c <= CJK_COMPAT_HI) ||
		                       (c >= CJK_RADICAL_LO && c <= CJK_RADICAL_HI);
		hits_d[CLS_ELLIPSIS] = (c == ELLIPSIS_CP);
		hits_d[CLS_PERIOD]   = period_char(c);
		hits_d[CLS_OMARK]    = omark_char(c);
		hits_d[CLS_COMMA]    = comma_char(c);
		hits_d[CLS_QUOTE]    = quote_char(c);
		hits_d[CLS_SYMBOL]   = symbol_char(c);
		hits_d[CLS_FOREIGN]  = 1'b1;
	end

	// priority order follows the class numbering
	always_comb begin
		if (hits_s1[CLS_SPACE])         cls_d = CLS_SPACE;
		else if (hits_s1[CLS_HANGUL])   cls_d = CLS_HANGUL;
		else if (hits_s1[CLS_LATIN])    cls_d = CLS_LATIN;
		else if (hits_s1[CLS_NUMBER])   cls_d = CLS_NUMBER;
		else if (hits_s1[CLS_CJK])      cls_d = CLS_CJK;
		else if (hits_s1[CLS_ELLIPSIS]) cls_d = CLS_ELLIPSIS;
		else if (hits_s1[CLS_PERIOD])   cls_d = CLS_PERIOD;
		else if (hits_s1[CLS_OMARK])    cls_d = CLS_OMARK;
		else if (hits_s1[CLS_COMMA])    cls_d = CLS_COMMA;
		else if (hits_s1[CLS_QUOTE])    cls_d = CLS_QUOTE;
		else if (hits_s1[CLS_SYMBOL])   cls_d = CLS_SYMBOL;
		else                            cls_d = CLS_FOREIGN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= s_tvalid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			hits_s1 <= hits_d;
		end
		if (adv_s2 && v_s1) begin
			cls_s2 <= cls_d;
		end
		if (adv_s3 && v_s2) begin
			cls_s3   <= cls_s2;
			merge_s3 <= merge_of(cls_s2);
			tag_s3   <= tag_of(cls_s2);
			err_s3   <= (cls_s2 == CLS_SPACE);
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {6'b0, tag_s3, merge_s3, cls_s3};
	assign m_tuser  = err_s3;

endmodule

// File: rtl/core/uct_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the character class tagger output stream, bound to
// the top level. Depends on uct_pkg.
module uct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);
	import uct_pkg::*;

	logic [3:0] cls;
	logic [1:0] merge;
	logic [3:0] tag;

	assign cls   = m_tdata[3:0];
	assign merge = m_tdata[5:4];
	assign tag   = m_tdata[9:6];

	// error flag only for space, and then the tag reads as zero
	a_err_space: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (cls == CLS_SPACE)) && (!m_tuser || tag == TAG_NNG))
		else $error("tag_error does not match space class");

	a_cls_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cls <= CLS_FOREIGN)
		else $error("char_class out of range");

	a_merge_sep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (cls == CLS_COMMA || cls == CLS_QUOTE || cls == CLS_SYMBOL)
		|-> merge == MERGE_SEPARATE)
		else $error("punctuation class with wrong merge mode");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output transaction changed");

endmodule

bind unicode_char_class_tagger_core uct_checker u_uct_checker (.*);
